@@ sv/rlfb_pkg.sv @@
// Package for the RGB LED frame builder: transaction structs, operation,
// result and register codes, controller states and frame constants.
// No dependencies.
package rlfb_pkg;

	// Default of the LED store depth.
	localparam int MAX_LEDS_DEF = 64;

	// Frame layout.
	localparam int          FRAME_BYTES = 28;
	localparam int          HDR_BYTES   = 4;
	localparam int          LED_BYTES   = 6;
	localparam logic [5:0]  CMD_CODE    = 6'h25;

	// Widths of the fields.
	localparam int GS_W     = 16;
	localparam int BRIGHT_W = 7;
	localparam int FLAGS_W  = 5;
	localparam int GROUPS_W = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	// Store entry: red, green and blue grayscale values.
	localparam int ENTRY_W = 3 * GS_W;

	// Input operations.
	typedef enum logic [1:0] {
		OP_SET_CHAN = 2'd0,
		OP_SET_LED  = 2'd1,
		OP_EMIT     = 2'd2,
		OP_RSVD     = 2'd3
	} op_t;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_ACK   = 2'd0,
		KIND_ERR   = 2'd1,
		KIND_FRAME = 2'd2
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FLAGS  = 3'd0,
		CFG_BR_RED = 3'd1,
		CFG_BR_GRN = 3'd2,
		CFG_BR_BLU = 3'd3,
		CFG_GROUPS = 3'd4
	} cfg_idx_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_RMW  = 2'd1,
		ST_EMIT = 2'd2
	} state_t;

	// One command transaction.
	typedef struct packed {
		logic [1:0]      op;
		logic [7:0]      index;
		logic [GS_W-1:0] red;
		logic [GS_W-1:0] green;
		logic [GS_W-1:0] blue;
		logic [GS_W-1:0] intensity;
	} cmd_t;

	// One result transaction.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic       last;
	} result_t;

endpackage

@@ sv/rlfb_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module rlfb_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/rgb_led_frame_builder.sv @@
// Top level of the RGB LED frame builder: LED store, command controller and
// frame byte sequencer. Depends on rlfb_pkg and rlfb_ram.
//
//  channel   ports                           direction  handshake
//  -------   -----------------------------   ---------  ----------------------
//  command   start, busy, cmd                in         start high, busy low
//  result    strobe, result                  out        strobe, one cycle each
//  config    cfg_we, cfg_index, cfg_data     in         cfg_we high
//
// Set-LED and rejected commands end on acceptance, the result in the next cycle.
// Set-channel reads the store entry, then writes the merged entry back.
// Emit accepts the command, then sends 28 frame bytes, one per cycle; the
// single read port of the store fetches one LED per six bytes.
// Reset sets control and config registers and clears the per-LED valid bits;
// an unwritten LED reads as zero, so no store clearing. The receiver cannot stall.
module rgb_led_frame_builder #(
	parameter int MAX_LEDS = rlfb_pkg::MAX_LEDS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  rlfb_pkg::cmd_t                        cmd,
	output logic                                  strobe,
	output rlfb_pkg::result_t                     result,
	input  logic                                  cfg_we,
	input  logic [rlfb_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rlfb_pkg::CFG_DATA_W-1:0]       cfg_data
);

	import rlfb_pkg::*;

	localparam int AW  = $clog2(MAX_LEDS);
	localparam int CAP = (MAX_LEDS / 4) * 4;

	// Configuration registers.
	logic [FLAGS_W-1:0]  flags_q;
	logic [BRIGHT_W-1:0] br_red_q;
	logic [BRIGHT_W-1:0] br_grn_q;
	logic [BRIGHT_W-1:0] br_blu_q;
	logic [GROUPS_W-1:0] groups_q;

	// Controller.
	state_t         state_q, state_d;
	logic [4:0]     cnt_q;
	logic [2:0]     bsel_q;
	logic [AW-1:0]  rd_led_q;
	logic [AW-1:0]  wr_addr_q;
	logic [1:0]     ch_q;
	logic [GS_W-1:0] inten_q;
	logic [ENTRY_W-1:0] led_q;
	logic           strobe_q, strobe_d;
	result_t        result_q, result_d;

	// Store and valid bits.
	logic [MAX_LEDS-1:0] valid_q;
	logic                rvalid_s1;
	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0]  ram_wdata, ram_rdata, rd_entry, merged;

	// Decode of the incoming command.
	logic          accept;
	logic [9:0]    usable;
	logic [15:0]   div_prod;
	logic [6:0]    chan_led;
	logic [7:0]    chan_rem;
	logic          chan_ok, led_ok, grp_ok;
	logic [31:0]   header;
	logic [7:0]    frame_byte;
	logic          emit_read, emit_latch;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// Usable LED count: four per group, capped by the store depth rounded down to a multiple of four.
	always_comb begin
		if ({3'b000, groups_q, 2'b00} < 10'(CAP)) begin
			usable = {3'b000, groups_q, 2'b00};
		end else begin
			usable = 10'(CAP);
		end
	end

	// Channel index divided by three through a reciprocal multiply.
	assign div_prod = 16'(cmd.index) * 16'd171;
	assign chan_led = div_prod[15:9];
	assign chan_rem = cmd.index - (8'(chan_led) * 8'd3);

	assign chan_ok = {3'b000, chan_led} < usable;
	assign led_ok  = {2'b00, cmd.index} < usable;
	assign grp_ok  = {cmd.index, 2'b11} < usable;

	// Frame header, MSB first.
	assign header = {CMD_CODE, flags_q, br_red_q, br_grn_q, br_blu_q};

	// Store reads during emission: the first LED at the third header byte, each
	// following one at the fifth byte of the current LED but the last.
	assign emit_read  = (state_q == ST_EMIT) &&
		((cnt_q == 5'd2) || ((cnt_q >= 5'(HDR_BYTES)) && (cnt_q < 5'd22) && (bsel_q == 3'd4)));
	assign emit_latch = (state_q == ST_EMIT) && (cnt_q < 5'(FRAME_BYTES - 1)) &&
		((cnt_q == 5'(HDR_BYTES - 1)) ||
		((cnt_q >= 5'(HDR_BYTES)) && (bsel_q == 3'(LED_BYTES - 1))));

	// Store port control.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = rd_led_q;
		if (state_q == ST_IDLE && accept && cmd.op == OP_SET_CHAN && chan_ok) begin
			ram_re    = 1'b1;
			ram_raddr = AW'(chan_led);
		end else if (emit_read) begin
			ram_re = 1'b1;
		end
	end

	assign rd_entry = rvalid_s1 ? ram_rdata : '0;

	// Merge of one channel into the entry read back.
	always_comb begin
		merged = rd_entry;
		case (ch_q)
			2'd0:    merged[3*GS_W-1:2*GS_W] = inten_q;
			2'd1:    merged[2*GS_W-1:GS_W]   = inten_q;
			default: merged[GS_W-1:0]        = inten_q;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_addr_q;
		ram_wdata = merged;
		if (state_q == ST_RMW) begin
			ram_we = 1'b1;
		end else if (state_q == ST_IDLE && accept && cmd.op == OP_SET_LED && led_ok) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(cmd.index);
			ram_wdata = {cmd.red, cmd.green, cmd.blue};
		end
	end

	rlfb_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_LEDS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Valid bits: an entry reads as zero until it is first written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (ram_re) begin
				rvalid_s1 <= valid_q[ram_raddr];
			end
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q  <= '0;
			br_red_q <= '0;
			br_grn_q <= '0;
			br_blu_q <= '0;
			groups_q <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FLAGS:  flags_q  <= cfg_data[FLAGS_W-1:0];
				CFG_BR_RED: br_red_q <= cfg_data[BRIGHT_W-1:0];
				CFG_BR_GRN: br_grn_q <= cfg_data[BRIGHT_W-1:0];
				CFG_BR_BLU: br_blu_q <= cfg_data[BRIGHT_W-1:0];
				CFG_GROUPS: groups_q <= cfg_data[GROUPS_W-1:0];
				default:    ;
			endcase
		end
	end

	// Byte of the frame at the current position.
	always_comb begin
		frame_byte = 8'h00;
		if (cnt_q < 5'(HDR_BYTES)) begin
			case (cnt_q[1:0])
				2'd0:    frame_byte = header[31:24];
				2'd1:    frame_byte = header[23:16];
				2'd2:    frame_byte = header[15:8];
				default: frame_byte = header[7:0];
			endcase
		end else begin
			case (bsel_q)
				3'd0:    frame_byte = led_q[15:8];
				3'd1:    frame_byte = led_q[7:0];
				3'd2:    frame_byte = led_q[31:24];
				3'd3:    frame_byte = led_q[23:16];
				3'd4:    frame_byte = led_q[47:40];
				default: frame_byte = led_q[39:32];
			endcase
		end
	end

	// Next state and next result.
	always_comb begin
		state_d  = state_q;
		strobe_d = 1'b0;
		result_d = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					strobe_d      = 1'b1;
					result_d.last = 1'b1;
					result_d.kind = KIND_ERR;
					case (cmd.op)
						OP_SET_CHAN: begin
							if (chan_ok) begin
								strobe_d = 1'b0;
								state_d  = ST_RMW;
							end
						end
						OP_SET_LED: begin
							if (led_ok) begin
								result_d.kind = KIND_ACK;
							end
						end
						OP_EMIT: begin
							if (grp_ok) begin
								strobe_d = 1'b0;
								state_d  = ST_EMIT;
							end
						end
						default: ;
					endcase
				end
			end
			ST_RMW: begin
				strobe_d      = 1'b1;
				result_d.kind = KIND_ACK;
				result_d.last = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_EMIT: begin
				strobe_d           = 1'b1;
				result_d.kind      = KIND_FRAME;
				result_d.data_byte = frame_byte;
				result_d.last      = (cnt_q == 5'(FRAME_BYTES - 1));
				if (cnt_q == 5'(FRAME_BYTES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State, result register and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			result_q <= '0;
			cnt_q    <= '0;
			bsel_q   <= '0;
		end else begin
			state_q  <= state_d;
			strobe_q <= strobe_d;
			result_q <= result_d;
			if (state_q == ST_EMIT) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q >= 5'(HDR_BYTES)) begin
					bsel_q <= (bsel_q == 3'(LED_BYTES - 1)) ? 3'd0 : bsel_q + 3'd1;
				end
			end else begin
				cnt_q  <= '0;
				bsel_q <= '0;
			end
		end
	end

	// Payload registers of the command in flight.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			wr_addr_q <= AW'(chan_led);
			ch_q      <= chan_rem[1:0];
			inten_q   <= cmd.intensity;
			rd_led_q  <= AW'({cmd.index, 2'b11});
		end else if (emit_read) begin
			rd_led_q <= rd_led_q - AW'(1);
		end
		if (emit_latch) begin
			led_q <= rd_entry;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

`ifndef SYNTH
	// A frame byte only follows a cycle spent emitting.
	a_frame_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.kind == KIND_FRAME |-> $past(state_q == ST_EMIT))
		else $error("frame byte without emission");

	// Frame bytes come back to back until the last one.
	a_frame_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe)
		else $error("gap inside a frame");

	// An LED is latched only after the store read for it was issued.
	a_latch_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		emit_latch |-> $past(ram_re))
		else $error("LED latched without a store read");

	// A valid emit command starts the frame sequence.
	a_emit_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.op == OP_EMIT && grp_ok |=> state_q == ST_EMIT && !strobe)
		else $error("emit command did not start a frame");
`endif

endmodule
